### design/ripe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ripe_pkg: raster image print encoder shared definitions
// Item modes, header positions, command bytes and register defaults.
// ---------------------------------------------------------------------------
package ripe_pkg;

	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int BAND_ROWS_DEF   = 24;
	localparam int FLUSH_BURST_DEF = 64;

	localparam int CFG_W       = 13;
	localparam int MAX_HEIGHT  = 4096;
	// h + BAND_ROWS - 1 stays below 2**13 for BAND_ROWS up to 4096
	localparam int XW          = 13;
	localparam int RECIP_SHIFT = 13;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd384;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1;
	localparam logic [7:0]       THRESH_RST = 8'hc0;

	localparam logic [7:0] CMD_ESC   = 8'd27;
	localparam logic [7:0] CMD_INIT  = 8'd64;
	localparam logic [7:0] CMD_GS    = 8'd29;
	localparam logic [7:0] CMD_V     = 8'd118;
	localparam logic [7:0] CMD_ZERO  = 8'd48;
	localparam logic [7:0] CMD_MODE  = 8'd0;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_THRESH = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		BURST_IDLE,
		BURST_HEADER,
		BURST_PAD
	} burst_t;

	typedef enum logic [3:0] {
		HP_ESC  = 4'd0,
		HP_INIT = 4'd1,
		HP_GS   = 4'd2,
		HP_V    = 4'd3,
		HP_48   = 4'd4,
		HP_MODE = 4'd5,
		HP_XL   = 4'd6,
		HP_XH   = 4'd7,
		HP_YL   = 4'd8,
		HP_YH   = 4'd9
	} hdr_pos_t;

endpackage

### design/raster_image_print_encoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raster_image_print_encoder_core: raster bit image printer stream encoder
// Packs thresholded pixels into bytes behind a printer reset and raster
// header, and sends the padding rows of the last band as zero bytes.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+----------------------
//  in       | in_valid, in_stall, mode, pixel_blue      | one item / transaction
//  out      | out_valid, out_stall, out_byte,           | one byte / transaction
//           | last_of_run, image_done                   |
//  cfg      | cfg_write, cfg_index, cfg_data            | one register write
//
// Pixels stream at one per cycle while out_stall lets the output register load.
// A start item keeps the encoder busy sending the 10 header bytes and stalls
// the following transaction until the last of them is emitted; a flush item
// sending N zero bytes (up to FLUSH_BURST) stalls the next until the last one.
// out_stall holds the output register; the input register stalls behind it.
// Reset is asynchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module raster_image_print_encoder_core #(
	parameter int MAX_WIDTH   = ripe_pkg::MAX_WIDTH_DEF,
	parameter int BAND_ROWS   = ripe_pkg::BAND_ROWS_DEF,
	parameter int FLUSH_BURST = ripe_pkg::FLUSH_BURST_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [1:0]                 cfg_index,
	input  logic [ripe_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 mode,
	input  logic [7:0]                 pixel_blue,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       image_done
);

	localparam int CW       = ripe_pkg::CFG_W;
	localparam int XW       = ripe_pkg::XW;
	localparam int MAX_EFF  = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
	localparam int ROWB_W   = $clog2((MAX_EFF + 7) / 8 + 1);
	localparam int PADR_W   = (BAND_ROWS > 1) ? $clog2(BAND_ROWS) : 1;
	localparam int PAD_W    = PADR_W + ROWB_W;
	localparam int FB_W     = $clog2(FLUSH_BURST + 1);
	localparam int RECIP    = (1 << ripe_pkg::RECIP_SHIFT) / BAND_ROWS;
	localparam int PROD_W   = XW + ripe_pkg::RECIP_SHIFT + 1;

	// configuration
	logic [CW-1:0] image_width_q, image_height_q;
	logic [7:0]    dark_threshold_q;

	// input register
	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] blue_s1;

	// encoder state
	logic [CW-1:0]     col_q, col_d, row_q, row_d;
	logic [CW-1:0]     lat_w_q, lat_w_d, lat_h_q, lat_h_d;
	logic [7:0]        acc_q, acc_d;
	logic [2:0]        bitpos_q, bitpos_d;
	logic [PAD_W-1:0]  pad_left_q, pad_left_d;
	logic              active_q, active_d;
	ripe_pkg::burst_t  burst_q, burst_d;
	ripe_pkg::hdr_pos_t hdr_idx_q, hdr_idx_d;
	logic [FB_W-1:0]   pad_cnt_q, pad_cnt_d;
	logic              pad_done_q, pad_done_d;

	// header arithmetic
	logic [ROWB_W-1:0] rw_q, rw_d;
	logic [XW-1:0]     x_q, x_d;
	logic [PROD_W-1:0] prod_q;
	logic [XW-1:0]     qb_q, ph_q;
	logic [XW+7:0]     qb_full;
	logic [XW-1:0]     q_est, rem;
	logic [PADR_W-1:0] pad_rows;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q, done_q;

	logic       load_out, take_s1, in_accept, hdr_step;
	logic       emit, emit_last, emit_done;
	logic [7:0] emit_byte, hdr_byte, mask;
	logic [15:0] rw16, ph16;
	logic [CW-1:0] w_eff, h_eff;
	logic       row_end, pad_gt;
	logic [FB_W-1:0] burst_n;
	logic [PAD_W-1:0] pad_after;

	assign load_out  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !take_s1;
	assign in_accept = in_valid && !in_stall;
	assign hdr_step  = load_out && (burst_q == ripe_pkg::BURST_HEADER);

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign image_done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= ripe_pkg::WIDTH_RST;
			image_height_q   <= ripe_pkg::HEIGHT_RST;
			dark_threshold_q <= ripe_pkg::THRESH_RST;
		end else if (cfg_write) begin
			case (ripe_pkg::cfg_idx_t'(cfg_index))
				ripe_pkg::CFG_WIDTH:  image_width_q    <= cfg_data;
				ripe_pkg::CFG_HEIGHT: image_height_q   <= cfg_data;
				ripe_pkg::CFG_THRESH: dark_threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1 <= mode;
			blue_s1 <= pixel_blue;
		end
	end

	// band rounding: q = floor(x / BAND_ROWS) by reciprocal, then one correction
	assign q_est   = prod_q[ripe_pkg::RECIP_SHIFT +: XW];
	assign qb_full = (XW+8)'(q_est) * (XW+8)'(BAND_ROWS);
	assign rem     = x_q - qb_q;
	assign pad_rows = PADR_W'(ph_q - lat_h_q);

	always_ff @(posedge clk) begin
		if (hdr_step) begin
			case (hdr_idx_q)
				ripe_pkg::HP_INIT: prod_q <= PROD_W'(x_q) * PROD_W'(RECIP);
				ripe_pkg::HP_GS:   qb_q   <= qb_full[XW-1:0];
				ripe_pkg::HP_V:    ph_q   <= (rem >= XW'(BAND_ROWS)) ?
					qb_q + XW'(BAND_ROWS) : qb_q;
				default: ;
			endcase
		end
	end

	assign rw16 = 16'(rw_q);
	assign ph16 = 16'(ph_q);

	always_comb begin
		case (hdr_idx_q)
			ripe_pkg::HP_ESC:  hdr_byte = ripe_pkg::CMD_ESC;
			ripe_pkg::HP_INIT: hdr_byte = ripe_pkg::CMD_INIT;
			ripe_pkg::HP_GS:   hdr_byte = ripe_pkg::CMD_GS;
			ripe_pkg::HP_V:    hdr_byte = ripe_pkg::CMD_V;
			ripe_pkg::HP_48:   hdr_byte = ripe_pkg::CMD_ZERO;
			ripe_pkg::HP_MODE: hdr_byte = ripe_pkg::CMD_MODE;
			ripe_pkg::HP_XL:   hdr_byte = rw16[7:0];
			ripe_pkg::HP_XH:   hdr_byte = rw16[15:8];
			ripe_pkg::HP_YL:   hdr_byte = ph16[7:0];
			ripe_pkg::HP_YH:   hdr_byte = ph16[15:8];
			default:           hdr_byte = ripe_pkg::CMD_MODE;
		endcase
	end

	always_comb begin
		w_eff = image_width_q;
		if (w_eff == '0) begin
			w_eff = CW'(1);
		end else if (32'(w_eff) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end
		h_eff = image_height_q;
		if (h_eff == '0) begin
			h_eff = CW'(1);
		end else if (32'(h_eff) > ripe_pkg::MAX_HEIGHT) begin
			h_eff = CW'(ripe_pkg::MAX_HEIGHT);
		end
	end

	assign mask    = (blue_s1 < dark_threshold_q) ? (8'h80 >> bitpos_q) : 8'h00;
	assign row_end = ({1'b0, col_q} + (CW+1)'(1)) >= {1'b0, lat_w_q};
	assign pad_gt  = 32'(pad_left_q) > FLUSH_BURST;
	assign burst_n = pad_gt ? FB_W'(FLUSH_BURST) : FB_W'(pad_left_q);
	assign pad_after = pad_left_q - PAD_W'(burst_n);

	always_comb begin
		col_d      = col_q;
		row_d      = row_q;
		lat_w_d    = lat_w_q;
		lat_h_d    = lat_h_q;
		acc_d      = acc_q;
		bitpos_d   = bitpos_q;
		pad_left_d = pad_left_q;
		active_d   = active_q;
		burst_d    = burst_q;
		hdr_idx_d  = hdr_idx_q;
		pad_cnt_d  = pad_cnt_q;
		pad_done_d = pad_done_q;
		rw_d       = rw_q;
		x_d        = x_q;
		take_s1    = 1'b0;
		emit       = 1'b0;
		emit_byte  = 8'h00;
		emit_last  = 1'b0;
		emit_done  = 1'b0;
		if (load_out) begin
			case (burst_q)
				ripe_pkg::BURST_HEADER: begin
					emit      = 1'b1;
					emit_byte = hdr_byte;
					emit_last = (hdr_idx_q == ripe_pkg::HP_YH);
					if (hdr_idx_q == ripe_pkg::HP_48) begin
						pad_left_d = PAD_W'(pad_rows) * PAD_W'(rw_q);
					end
					if (emit_last) begin
						burst_d = ripe_pkg::BURST_IDLE;
					end else begin
						hdr_idx_d = ripe_pkg::hdr_pos_t'(hdr_idx_q + 4'd1);
					end
				end
				ripe_pkg::BURST_PAD: begin
					emit      = 1'b1;
					emit_last = (pad_cnt_q == FB_W'(1));
					emit_done = emit_last && pad_done_q;
					pad_cnt_d = pad_cnt_q - FB_W'(1);
					if (emit_last) begin
						burst_d = ripe_pkg::BURST_IDLE;
					end
				end
				default: begin
					take_s1 = valid_s1;
					if (valid_s1) begin
						case (ripe_pkg::mode_t'(mode_s1))
							ripe_pkg::MODE_START: begin
								lat_w_d    = w_eff;
								lat_h_d    = h_eff;
								rw_d       = ROWB_W'(({1'b0, w_eff} + (CW+1)'(7)) >> 3);
								x_d        = XW'(h_eff) + XW'(BAND_ROWS - 1);
								col_d      = '0;
								row_d      = '0;
								acc_d      = '0;
								bitpos_d   = '0;
								pad_left_d = '0;
								active_d   = 1'b1;
								emit       = 1'b1;
								emit_byte  = ripe_pkg::CMD_ESC;
								burst_d    = ripe_pkg::BURST_HEADER;
								hdr_idx_d  = ripe_pkg::HP_INIT;
							end
							ripe_pkg::MODE_PIXEL: begin
								if (active_q && row_q < lat_h_q) begin
									acc_d    = acc_q | mask;
									bitpos_d = bitpos_q + 3'd1;
									if (row_end) begin
										col_d = '0;
										row_d = row_q + CW'(1);
									end else begin
										col_d = col_q + CW'(1);
									end
									if (bitpos_d == 3'd0 || row_end) begin
										emit      = 1'b1;
										emit_byte = acc_d;
										emit_last = 1'b1;
										acc_d     = '0;
										bitpos_d  = '0;
										if (row_end && row_d >= lat_h_q &&
											pad_left_q == '0) begin
											emit_done = 1'b1;
											active_d  = 1'b0;
										end
									end
								end
							end
							ripe_pkg::MODE_FLUSH: begin
								if (active_q && row_q >= lat_h_q && pad_left_q != '0) begin
									pad_left_d = pad_after;
									emit       = 1'b1;
									emit_last  = (burst_n == FB_W'(1));
									emit_done  = emit_last && (pad_after == '0);
									if (pad_after == '0) begin
										active_d = 1'b0;
									end
									if (!emit_last) begin
										burst_d    = ripe_pkg::BURST_PAD;
										pad_cnt_d  = burst_n - FB_W'(1);
										pad_done_d = (pad_after == '0);
									end
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			lat_w_q     <= '0;
			lat_h_q     <= '0;
			acc_q       <= '0;
			bitpos_q    <= '0;
			pad_left_q  <= '0;
			active_q    <= 1'b0;
			burst_q     <= ripe_pkg::BURST_IDLE;
			hdr_idx_q   <= ripe_pkg::HP_ESC;
			pad_cnt_q   <= '0;
			pad_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			col_q      <= col_d;
			row_q      <= row_d;
			lat_w_q    <= lat_w_d;
			lat_h_q    <= lat_h_d;
			acc_q      <= acc_d;
			bitpos_q   <= bitpos_d;
			pad_left_q <= pad_left_d;
			active_q   <= active_d;
			burst_q    <= burst_d;
			hdr_idx_q  <= hdr_idx_d;
			pad_cnt_q  <= pad_cnt_d;
			pad_done_q <= pad_done_d;
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		rw_q <= rw_d;
		x_q  <= x_d;
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
			done_q     <= emit_done;
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: raster image print encoder testbench
// Drives start, pixel, flush and unused-mode items into the encoder and predicts the
// printer byte stream. The stream holds the reset pair, the raster header,
// the packed pixel bytes and the zero padding rows of the last band. Every
// byte leaving the block is checked against the oldest predicted byte.
// Both channels idle at random. One stretch holds the output off for a long
// time so that the block backs up into its input.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int          CLK_HALF      = 6;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          TAIL_CYCLES   = 80;
	localparam int          RANDOM_ITEMS  = 290;
	localparam logic [1:0]  MODE_UNUSED   = 2'd3;
	localparam logic [1:0]  CFG_UNUSED    = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} out_beat_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_write;
	logic [1:0]       cfg_index;
	logic [ripe_pkg::CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       mode;
	logic [7:0]       pixel_blue;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       out_byte;
	logic             last_of_run;
	logic             image_done;

	// encoder state as the predictor sees it
	logic [12:0] reg_width;
	logic [12:0] reg_height;
	logic [7:0]  reg_thresh;
	logic [12:0] col;
	logic [12:0] row;
	logic [12:0] lat_w;
	logic [12:0] lat_h;
	logic [7:0]  acc;
	logic [2:0]  bitpos;
	logic [13:0] pad_left;
	bit          active;

	out_beat_t pending_bytes[$];
	int        mismatches;
	int        image_items;
	int        rx_gap;
	int        stall_hold_left;
	bit        tx_idle;
	bit        rx_idle;

	raster_image_print_encoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.pixel_blue  (pixel_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.image_done  (image_done)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin : watchdog
		#(30_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void expect_beat(input logic [7:0] data, input logic last,
			input logic done);
		out_beat_t beat;
		beat = '{data, last, done};
		pending_bytes.insert(pending_bytes.size(), beat);
	endfunction

	// returns 1 when the item changes the encoder state
	function automatic bit encode_item(input logic [1:0] m, input logic [7:0] blue);
		int         w;
		int         h;
		int         rw;
		int         ph;
		int         n;
		bit         row_end;
		logic       done;
		logic [7:0] hdr [10];
		case (m)
			ripe_pkg::MODE_START: begin
				w = (reg_width == 0) ? 1 :
					(reg_width > ripe_pkg::MAX_WIDTH_DEF) ? ripe_pkg::MAX_WIDTH_DEF :
					int'(reg_width);
				h = (reg_height == 0) ? 1 :
					(reg_height > ripe_pkg::MAX_HEIGHT) ? ripe_pkg::MAX_HEIGHT :
					int'(reg_height);
				rw = (w + 7) / 8;
				ph = ((h + ripe_pkg::BAND_ROWS_DEF - 1) / ripe_pkg::BAND_ROWS_DEF) *
					ripe_pkg::BAND_ROWS_DEF;
				lat_w = w[12:0];
				lat_h = h[12:0];
				col = '0;
				row = '0;
				acc = '0;
				bitpos = '0;
				pad_left = 14'((ph - h) * rw);
				active = 1'b1;
				hdr = '{ripe_pkg::CMD_ESC, ripe_pkg::CMD_INIT, ripe_pkg::CMD_GS,
					ripe_pkg::CMD_V, ripe_pkg::CMD_ZERO, ripe_pkg::CMD_MODE,
					rw[7:0], rw[15:8], ph[7:0], ph[15:8]};
				for (int k = 0; k < 10; k++)
					expect_beat(hdr[k], k == 9, 1'b0);
				return 1'b1;
			end
			ripe_pkg::MODE_PIXEL: begin
				if (!active || row >= lat_h)
					return 1'b0;
				if (blue < reg_thresh)
					acc = acc | (8'h80 >> bitpos);
				bitpos = bitpos + 3'd1;
				row_end = (col + 13'd1 >= lat_w);
				if (row_end) begin
					col = '0;
					row = row + 13'd1;
				end else begin
					col = col + 13'd1;
				end
				if (bitpos != 0 && !row_end)
					return 1'b1;
				done = 1'b0;
				if (row_end && row >= lat_h && pad_left == 0) begin
					done = 1'b1;
					active = 1'b0;
				end
				expect_beat(acc, 1'b1, done);
				acc = '0;
				bitpos = '0;
				return 1'b1;
			end
			ripe_pkg::MODE_FLUSH: begin
				if (!active || row < lat_h || pad_left == 0)
					return 1'b0;
				n = (pad_left > ripe_pkg::FLUSH_BURST_DEF) ? ripe_pkg::FLUSH_BURST_DEF :
					int'(pad_left);
				pad_left = pad_left - 14'(n);
				for (int k = 0; k < n; k++)
					expect_beat(8'h00, k == n - 1, (k == n - 1) && (pad_left == 0));
				if (pad_left == 0)
					active = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// output side: checks each transaction and draws the stall pattern
	initial begin : result_checker
		out_beat_t want;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && !out_stall) begin
				if (pending_bytes.size() == 0) begin
					$display("%0t: unexpected byte, expected none, got %0d", $time, out_byte);
					mismatches++;
				end else begin
					want = pending_bytes.pop_front();
					compare_field("out_byte", want.data, out_byte);
					compare_field("last_of_run", {7'd0, want.last}, {7'd0, last_of_run});
					compare_field("image_done", {7'd0, want.done}, {7'd0, image_done});
				end
				rx_gap = rx_idle ? $urandom_range(0, 11) : 0;
			end
			@(negedge clk);
			if (stall_hold_left > 0) begin
				out_stall <= 1'b1;
				stall_hold_left--;
			end else if (rx_gap > 0) begin
				out_stall <= 1'b1;
				rx_gap--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// entered and left at a falling edge; valid stays up for a following item
	task automatic send_item(input logic [1:0] m, input logic [7:0] blue);
		int gap;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (encode_item(m, blue))
			image_items++;
		in_valid <= 1'b1;
		mode <= m;
		pixel_blue <= blue;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		case (idx)
			ripe_pkg::CFG_WIDTH:  reg_width = value;
			ripe_pkg::CFG_HEIGHT: reg_height = value;
			ripe_pkg::CFG_THRESH: reg_thresh = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [12:0] w, input logic [12:0] h,
			input logic [7:0] t);
		write_reg(ripe_pkg::CFG_WIDTH, w);
		write_reg(ripe_pkg::CFG_HEIGHT, h);
		write_reg(ripe_pkg::CFG_THRESH, {5'd0, t});
	endtask

	task automatic test_idle_items();
		send_item(ripe_pkg::MODE_PIXEL, 8'h00);
		send_item(ripe_pkg::MODE_FLUSH, 8'hff);
		send_item(MODE_UNUSED, 8'ha5);
		wait_all_results();
	endtask

	task automatic test_default_header();
		send_item(ripe_pkg::MODE_START, 8'h5a);
		wait_all_results();
	endtask

	task automatic test_clamped_geometry();
		// zero width and height count as one; padding is 23 single-byte rows
		set_geometry(13'd0, 13'd0, 8'd0);
		write_reg(CFG_UNUSED, 13'h1fff);
		send_item(ripe_pkg::MODE_START, 8'h00);
		send_item(ripe_pkg::MODE_FLUSH, 8'h00);
		send_item(ripe_pkg::MODE_PIXEL, 8'h00);
		send_item(ripe_pkg::MODE_PIXEL, 8'hff);
		send_item(ripe_pkg::MODE_FLUSH, 8'h00);
		wait_all_results();
		// oversize registers clamp, second start abandons the first image
		set_geometry(13'h1fff, 13'h1fff, 8'hff);
		send_item(ripe_pkg::MODE_START, 8'h00);
		send_item(ripe_pkg::MODE_START, 8'hff);
		wait_all_results();
	endtask

	task automatic test_threshold_extremes();
		logic [7:0] blues [9];
		blues = '{8'hff, 8'hfe, 8'h00, 8'h80, 8'hff, 8'h01, 8'hfe, 8'hff, 8'hc8};
		set_geometry(13'd9, 13'd1, 8'hff);
		send_item(ripe_pkg::MODE_START, 8'h00);
		foreach (blues[i])
			send_item(ripe_pkg::MODE_PIXEL, blues[i]);
		send_item(ripe_pkg::MODE_FLUSH, 8'h00);
		wait_all_results();
	endtask

	task automatic test_output_hold();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_geometry(13'd16, 13'd2, 8'd128);
		@(posedge clk);
		stall_hold_left = 300;
		@(negedge clk);
		send_item(ripe_pkg::MODE_START, 8'h00);
		repeat (32)
			send_item(ripe_pkg::MODE_PIXEL, 8'($urandom_range(0, 255)));
		send_item(ripe_pkg::MODE_FLUSH, 8'h00);
		wait_all_results();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_random_images();
		int         sel;
		int         w;
		int         h;
		int         total;
		int         cut;
		int         thr_at;
		int         near;
		bit         abandon;
		logic [7:0] blue;
		image_items = 0;
		while (image_items < RANDOM_ITEMS) begin
			wait_all_results();
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				case ($urandom_range(0, 3))
					0: w = 0;
					1: w = ripe_pkg::MAX_WIDTH_DEF;
					2: w = ripe_pkg::MAX_WIDTH_DEF + 1;
					default: w = 8191;
				endcase
				case ($urandom_range(0, 3))
					0: h = 0;
					1: h = ripe_pkg::MAX_HEIGHT;
					2: h = ripe_pkg::MAX_HEIGHT - 1;
					default: h = 8191;
				endcase
			end else if (sel < 4) begin
				w = $urandom_range(17, 40);
				h = $urandom_range(1, 3);
			end else begin
				sel = $urandom_range(0, 19);
				if (sel < 11) begin
					w = $urandom_range(1, 16);
					h = $urandom_range(1, 3);
				end else if (sel < 15) begin
					w = $urandom_range(1, 4);
					h = ripe_pkg::BAND_ROWS_DEF;
				end else if (sel < 17) begin
					w = $urandom_range(1, 4);
					h = ripe_pkg::BAND_ROWS_DEF + $urandom_range(1, 2);
				end else begin
					w = $urandom_range(1, 12);
					h = $urandom_range(4, 8);
				end
			end
			sel = $urandom_range(0, 9);
			set_geometry(w[12:0], h[12:0], (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 :
				8'($urandom_range(0, 255)));
			send_item(ripe_pkg::MODE_START, 8'($urandom_range(0, 255)));
			// oversize geometries get at most four pixels, then the next start abandons them
			total = (w * h > 0 && w <= 40 && h <= 26) ? w * h : $urandom_range(1, 5);
			abandon = (w > 40 || h > 26 || w == 0 || h == 0 || $urandom_range(0, 9) == 0);
			cut = abandon ? $urandom_range(0, total - 1) : total;
			thr_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : -1;
			for (int p = 0; p < cut; p++) begin
				if (p == thr_at) begin
					wait_all_results();
					write_reg(ripe_pkg::CFG_THRESH, 13'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 24) == 0)
					send_item($urandom_range(0, 1) ? MODE_UNUSED : ripe_pkg::MODE_FLUSH,
						8'($urandom_range(0, 255)));
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					blue = 8'h00;
				end else if (sel == 1) begin
					blue = 8'hff;
				end else if (sel == 2) begin
					near = int'(reg_thresh) - int'($urandom_range(0, 1));
					blue = (near < 0) ? 8'h00 : near[7:0];
				end else begin
					blue = 8'($urandom_range(0, 255));
				end
				send_item(ripe_pkg::MODE_PIXEL, blue);
			end
			if (!abandon) begin
				if ($urandom_range(0, 3) == 0)
					send_item(ripe_pkg::MODE_PIXEL, 8'($urandom_range(0, 255)));
				while (active && pad_left != 0)
					send_item(ripe_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) == 0)
					send_item(ripe_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)));
			end
		end
		wait_all_results();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = ripe_pkg::CFG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = ripe_pkg::MODE_START;
		pixel_blue = 8'h00;
		reg_width = ripe_pkg::WIDTH_RST;
		reg_height = ripe_pkg::HEIGHT_RST;
		reg_thresh = ripe_pkg::THRESH_RST;
		col = '0;
		row = '0;
		lat_w = '0;
		lat_h = '0;
		acc = '0;
		bitpos = '0;
		pad_left = '0;
		active = 1'b0;
		mismatches = 0;
		image_items = 0;
		rx_gap = 0;
		stall_hold_left = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_items();
		test_default_header();
		test_clamped_geometry();
		test_threshold_extremes();
		test_output_hold();
		test_random_images();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
